// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Every check is clocked on the rising edge and is masked while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside of reset.
`define TK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that forces a condition in the next cycle.
`define TK_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/tk_pkg.sv =====
// Package for the top-k sorted list: transaction payload types and the entry type.
// No dependencies.
package tk_pkg;

    localparam int unsigned SCORE_W  = 32;
    localparam int unsigned STAMP_W  = 32;
    localparam int unsigned PLAYER_W = 16;
    localparam int unsigned RANK_W   = 4;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [SCORE_W-1:0]  new_score;
        logic [STAMP_W-1:0]  new_time;
        logic [PLAYER_W-1:0] new_player;
        logic [RANK_W-1:0]   read_rank;
    } t_in;

    typedef struct packed {
        logic [RANK_W-1:0]   placed_rank;
        logic                entry_valid;
        logic [SCORE_W-1:0]  out_score;
        logic [STAMP_W-1:0]  out_time;
        logic [PLAYER_W-1:0] out_player;
        logic [RANK_W-1:0]   entry_count;
    } t_out;

    typedef struct packed {
        logic [SCORE_W-1:0]  score;
        logic [STAMP_W-1:0]  stamp;
        logic [PLAYER_W-1:0] player;
    } t_entry;

endpackage

// ===== rtl/tk_cmp.sv =====
// Rank compare unit, shared by every step of the insert walk.
// Depends on tk_pkg.
module tk_cmp
    import tk_pkg::*;
(
    input  t_entry i_stored,
    input  t_entry i_new,
    output logic   o_below
);

    // Higher score wins; on equal score the earlier stamp wins.
    // Exact equals do not rank below, so a new entry lands after them.
    always_comb begin
        if (i_stored.score != i_new.score) begin
            o_below = i_stored.score < i_new.score;
        end else begin
            o_below = i_stored.stamp > i_new.stamp;
        end
    end

endmodule

// ===== rtl/top_k_sorted_insert.sv =====
// Top-k sorted list over tk_pkg and tk_cmp. A full table first checks an insert against
// the last entry and drops it if it does not beat it. The walk then fetches the entry
// above the target slot and compares: a lower-ranked one shifts down, else the new entry
// lands. Reads and dropped inserts skip the walk. One read port and compare unit serve it.
// One transaction at a time: the next is taken the cycle after the result loads.
// Sync active-low reset clears count, sequencer and output valid; entry memory is not.
module top_k_sorted_insert
    import tk_pkg::*;
#(
    parameter int unsigned DEPTH = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // input channel
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_stall,
    // output channel
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_stall
);

    // AW indexes a slot, CW holds a count up to DEPTH itself.
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned VW = (CW > RANK_W) ? CW : RANK_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0; // wait for a transaction
    localparam logic [2:0] S_CHK   = 3'd1; // full table: does the new entry beat the last one
    localparam logic [2:0] S_RD    = 3'd2; // fetch the entry above the target slot, or at rank 0 drop the new entry in
    localparam logic [2:0] S_CMP   = 3'd3; // shift it down or drop the new entry in
    localparam logic [2:0] S_RDATA = 3'd4; // read transaction: data arrives
    localparam logic [2:0] S_DONE  = 3'd5; // hand result to the output register

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_held, n_held;
    logic [AW-1:0] r_idx, n_idx;      // slot the new entry may take
    t_entry        r_new, n_new;
    logic          r_rvalid, n_rvalid; // read transaction hits a held rank
    t_out          r_res, n_res;       // finished result awaiting the output register
    logic          r_ov;
    t_out          r_out;
    t_out          out_res;            // finished result with the final entry count

    // Entry memory: one write and one registered read per cycle
    t_entry        r_mem [DEPTH];
    t_entry        r_rd;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_entry        mem_wdata;

    logic          below;
    logic          in_accept;
    logic          out_free;
    logic          full;
    logic          hit;

    tk_cmp u_cmp (
        .i_stored (r_rd),
        .i_new    (r_new),
        .o_below  (below)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_ov || !i_out_stall;
    assign full        = (r_held == CW'(DEPTH));
    assign hit         = VW'(i_in_data.read_rank) < VW'(r_held);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_comb begin
        n_state   = r_state;
        n_held    = r_held;
        n_idx     = r_idx;
        n_new     = r_new;
        n_rvalid  = r_rvalid;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_idx;
        mem_raddr = r_idx;
        mem_wdata = r_new;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_new.score  = i_in_data.new_score;
                    n_new.stamp  = i_in_data.new_time;
                    n_new.player = i_in_data.new_player;
                    n_res        = '0;
                    n_res.placed_rank = RANK_W'(DEPTH);
                    if (i_in_data.kind == KIND_INSERT) begin
                        if (full) begin
                            mem_re    = 1'b1;
                            mem_raddr = AW'(DEPTH - 1);
                            n_state   = S_CHK;
                        end else begin
                            n_idx   = AW'(r_held);
                            n_state = S_RD;
                        end
                    end else begin
                        n_rvalid  = hit;
                        mem_re    = hit;
                        mem_raddr = AW'(i_in_data.read_rank);
                        n_state   = S_RDATA;
                    end
                end
            end
            S_CHK: begin
                if (below) begin
                    n_idx   = AW'(DEPTH - 1);
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE; // not kept, nothing changes
                end
            end
            S_RD: begin
                if (r_idx == '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    n_res.placed_rank = '0;
                    if (!full) n_held = r_held + 1'b1;
                    n_state   = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx - 1'b1;
                    n_state   = S_CMP;
                end
            end
            S_CMP: begin
                mem_we = 1'b1;
                if (below) begin
                    mem_wdata = r_rd; // shift the fetched entry down one rank
                    n_idx     = r_idx - 1'b1;
                    n_state   = S_RD;
                end else begin
                    n_res.placed_rank = RANK_W'(r_idx);
                    if (!full) n_held = r_held + 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_RDATA: begin
                if (r_rvalid) begin
                    n_res.entry_valid = 1'b1;
                    n_res.out_score   = r_rd.score;
                    n_res.out_time    = r_rd.stamp;
                    n_res.out_player  = r_rd.player;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Count is final by S_DONE
    always_comb begin
        out_res             = r_res;
        out_res.entry_count = RANK_W'(r_held);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            if (r_state == S_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_new    <= n_new;
        r_rvalid <= n_rvalid;
        r_res    <= n_res;
        if (r_state == S_DONE && out_free) begin
            r_out <= out_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) r_rd <= r_mem[mem_raddr];
    end

endmodule

// ===== rtl/tk_checker.sv =====
// Port-level checks for the top-k sorted list, bound to the top level.
// Depends on tk_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tk_checker
    import tk_pkg::*;
#(
    parameter int unsigned DEPTH = 10
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input t_in  i_in_data,
    input logic o_in_stall,
    input logic o_out_valid,
    input t_out o_out_data,
    input logic i_out_stall
);

    logic in_hold;
    logic out_hold;
    logic read_hit;
    logic no_entry;
    logic zero_entry;
    logic placed;

    assign in_hold    = i_in_valid && o_in_stall;
    assign out_hold   = o_out_valid && i_out_stall;
    assign read_hit   = o_out_valid && o_out_data.entry_valid;
    assign no_entry   = o_out_valid && !o_out_data.entry_valid;
    assign zero_entry = (o_out_data.out_score == '0) && (o_out_data.out_time == '0) &&
                        (o_out_data.out_player == '0);
    assign placed     = (DEPTH < 16) && o_out_valid &&
                        (o_out_data.placed_rank != RANK_W'(DEPTH));

    // A stalled input transaction holds.
    `TK_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_hold, i_in_valid && $stable(i_in_data), "stalled transaction changed")

    // A result stalled on the output holds.
    `TK_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_hold, o_out_valid && $stable(o_out_data), "stalled result changed")

    // A read result never carries a placed rank.
    `TK_ASSERT(a_read_rank, i_clk, i_rst_n, !read_hit || (o_out_data.placed_rank == RANK_W'(DEPTH)), "read result with placed rank")

    // An invalid or insert result has zero entry fields.
    `TK_ASSERT(a_zero_fields, i_clk, i_rst_n, !no_entry || zero_entry, "nonzero fields without entry")

    // A placed rank lies below the count of held entries.
    `TK_ASSERT(a_rank_in_count, i_clk, i_rst_n, !placed || (o_out_data.placed_rank < o_out_data.entry_count), "placed rank past entry count")

endmodule

bind top_k_sorted_insert tk_checker #(.DEPTH(DEPTH)) u_tk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

// ===== verif/top_k_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for top_k_sorted_insert: watches both channels, keeps its own ranked table
// and compares every result transaction field by field. Depends on tk_pkg.
module top_k_checker
    import tk_pkg::*;
#(
    parameter int unsigned DEPTH = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);

    t_entry      board [DEPTH];
    int unsigned held;
    t_out        awaited_replies [$];
    int          fails;

    // Apply one transaction to the table and return the reply it should produce.
    function automatic t_out board_step(t_in item);
        t_out        reply;
        int unsigned pos;
        int unsigned last;
        int unsigned i;
        reply             = '0;
        reply.placed_rank = RANK_W'(DEPTH);
        if (item.kind == KIND_INSERT) begin
            pos = 0;
            // equals (same score and stamp) stay ahead of the new entry
            while (pos < held && (board[pos].score > item.new_score ||
                   (board[pos].score == item.new_score && board[pos].stamp <= item.new_time)))
                pos++;
            if (pos < DEPTH) begin
                last = (held < DEPTH) ? held : DEPTH - 1;
                for (i = last; i > pos; i--)
                    board[i] = board[i - 1];
                board[pos].score  = item.new_score;
                board[pos].stamp  = item.new_time;
                board[pos].player = item.new_player;
                if (held < DEPTH)
                    held++;
                reply.placed_rank = RANK_W'(pos);
            end
        end else if (item.read_rank < held) begin
            reply.entry_valid = 1'b1;
            reply.out_score   = board[item.read_rank].score;
            reply.out_time    = board[item.read_rank].stamp;
            reply.out_player  = board[item.read_rank].player;
        end
        reply.entry_count = RANK_W'(held);
        return reply;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            held  = 0;
            fails = 0;
            awaited_replies.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_replies.size() == 0) begin
                    $error("unexpected result transaction: %p", i_out_data);
                    fails++;
                end else begin
                    want = awaited_replies.pop_front();
                    check_field("placed_rank", 32'(want.placed_rank),
                                32'(i_out_data.placed_rank));
                    check_field("entry_valid", 32'(want.entry_valid),
                                32'(i_out_data.entry_valid));
                    check_field("out_score", want.out_score, i_out_data.out_score);
                    check_field("out_time", want.out_time, i_out_data.out_time);
                    check_field("out_player", 32'(want.out_player),
                                32'(i_out_data.out_player));
                    check_field("entry_count", 32'(want.entry_count),
                                32'(i_out_data.entry_count));
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_replies = {awaited_replies, board_step(i_in_data)};
        end
        // published with NBA so readers at this edge see the previous value
        o_pending    <= awaited_replies.size();
        o_fail_count <= fails;
    end

endmodule

// ===== verif/top_k_sorted_insert_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for top_k_sorted_insert: clock, reset, stimulus and verdict.
// Depends on tk_pkg, the block itself and top_k_checker.
module top_k_sorted_insert_tb;
    import tk_pkg::*;

    localparam int unsigned DEPTH        = 10;
    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;
    logic i_out_stall = 1'b0;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    logic hold_req    = 1'b0;   // asks the receiver for its one long hold-off

    // sender pacing and random-score state
    int unsigned burst_left  = 0;
    int unsigned score_floor = 0;
    t_in         prev_insert = '0;

    always #5 i_clk = ~i_clk;

    top_k_sorted_insert #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall)
    );

    top_k_checker #(
        .DEPTH(DEPTH)
    ) scoreboard (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("top_k_sorted_insert_tb failed");
            $finish;
        end
    end

    // Insert transaction; read_rank is don't-care, so it carries noise.
    function automatic t_in mk_insert(logic [31:0] score, logic [31:0] stamp,
                                      logic [15:0] player);
        t_in item;
        item.kind       = KIND_INSERT;
        item.new_score  = score;
        item.new_time   = stamp;
        item.new_player = player;
        item.read_rank  = RANK_W'($urandom);
        return item;
    endfunction

    // Read transaction; the entry fields are don't-care and carry noise.
    function automatic t_in mk_read(logic [3:0] rank);
        t_in item;
        item.kind       = KIND_READ;
        item.new_score  = $urandom;
        item.new_time   = $urandom;
        item.new_player = 16'($urandom);
        item.read_rank  = rank;
        return item;
    endfunction

    // Random transaction. Scores mostly sit just above a slowly rising floor, so new
    // entries land at every rank of a full table instead of being dropped. Stamps come
    // from a tiny pool to force ties, and some inserts repeat the score and stamp of the last one.
    function automatic t_in next_random_item();
        t_in         item;
        int unsigned pick;
        item = mk_read(RANK_W'($urandom));
        if ($urandom_range(0, 99) < 35)
            return item;
        item.kind = KIND_INSERT;
        pick      = $urandom_range(0, 99);
        if (pick < 8) begin
            // same score and stamp as an earlier entry
            item.new_score = prev_insert.new_score;
            item.new_time  = prev_insert.new_time;
        end else if (pick < 9) begin
            item.new_score = $urandom;
            item.new_time  = $urandom;
        end else if (pick < 18) begin
            // below the floor: mostly lands below a full table
            item.new_score = $urandom_range(0, score_floor);
            item.new_time  = $urandom;
        end else begin
            if ($urandom_range(0, 31) == 0 && score_floor < 32'hE000_0000)
                score_floor += $urandom_range(0, 1 << 28);
            else
                score_floor += $urandom_range(0, 3);
            item.new_score = score_floor + $urandom_range(0, 15);
            case ($urandom_range(0, 9))
                0:       item.new_time = '0;
                1:       item.new_time = '1;
                2:       item.new_time = $urandom;
                default: item.new_time = $urandom_range(0, 3);
            endcase
        end
        prev_insert = item;
        return item;
    endfunction

    // Hold one transaction on the input channel until the block takes it.
    task automatic offer(t_in item);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // Offer, then either stay in the current burst or drop valid for a random gap.
    task automatic send_paced(t_in item);
        offer(item);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 20);
        end
    endtask

    // Stop offering until every predicted result has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
    endtask

    // Receiver: phases of no stall, light and heavy random stall or toggling stall, plus
    // one long hold-off on request while the sender keeps going, so the input side backs up.
    initial begin : out_stall_pattern
        int unsigned span;
        int unsigned mode;
        bit          hold_done;
        hold_done = 1'b0;
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(posedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end
            span = $urandom_range(1, 40);
            mode = $urandom_range(0, 3);
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 1) == 0);
                    2:       i_out_stall <= ($urandom_range(0, 4) != 0);
                    default: i_out_stall <= ~i_out_stall;
                endcase
            end
        end
    end

    initial begin : stimulus
        int unsigned n;
        // synchronous reset
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reads of an empty table, extremes, ties, filling, overflow.
        send_paced(mk_read(4'd0));
        send_paced(mk_read(4'd15));
        send_paced(mk_insert(32'hFFFF_FFFF, 32'h0, 16'hFFFF));
        send_paced(mk_insert(32'h0, 32'hFFFF_FFFF, 16'h0));
        send_paced(mk_insert(32'd100, 32'd5, 16'd1));
        send_paced(mk_insert(32'd100, 32'd5, 16'd2));   // exact tie goes after
        send_paced(mk_insert(32'd100, 32'd4, 16'd3));   // earlier stamp wins
        send_paced(mk_insert(32'd100, 32'd6, 16'd4));
        for (n = 0; n < 4; n++)
            send_paced(mk_insert(32'd50, 32'd7, 16'(5 + n)));
        // table is full; an equal of the last entry is not kept
        send_paced(mk_insert(32'h0, 32'hFFFF_FFFF, 16'd9));
        // better entry pushes the last one out
        send_paced(mk_insert(32'd200, 32'd0, 16'hA5A5));
        send_paced(mk_read(4'd0));
        send_paced(mk_read(4'd3));
        send_paced(mk_read(4'd9));
        send_paced(mk_read(4'd10));
        send_paced(mk_read(4'd15));
        drain();

        // Random part, with the long receiver hold-off and one mid-run drain.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 600)
                hold_req <= 1'b1;
            if (n == 1200)
                drain();
            send_paced(next_random_item());
        end

        drain();
        repeat (2 * DEPTH + 8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("top_k_sorted_insert_tb passed");
        else
            $display("top_k_sorted_insert_tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tk_pkg.sv
rtl/tk_cmp.sv
rtl/top_k_sorted_insert.sv
rtl/tk_checker.sv
verif/top_k_checker.sv
verif/top_k_sorted_insert_tb.sv
